### design/tagged_line_router_assert.svh
// ----------------------------------------------------------------------------
// tagged_line_router assertion macros
// Concurrent checks on the clock, muted while reset is high.
// ----------------------------------------------------------------------------
`ifndef TAGGED_LINE_ROUTER_ASSERT_SVH
`define TAGGED_LINE_ROUTER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define TLR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TLR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/tlr_pkg.sv
// ----------------------------------------------------------------------------
// tlr_pkg
// Shared types and constants of the tagged line router.
// ----------------------------------------------------------------------------
package tlr_pkg;

   localparam logic [7:0] NEWLINE_BYTE = 8'd10;
   localparam logic [7:0] SPACE_BYTE   = 8'd32;
   localparam logic [7:0] ZERO_BYTE    = 8'd0;

   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_CURSOR = 2'd1;
   localparam logic [1:0] KIND_CHAR   = 2'd2;

   // tags, left justified, zero padded
   localparam logic [31:0] TAG_RTC  = {"RTC", 8'h00};
   localparam logic [31:0] TAG_RSSI = "RSSI";
   localparam logic [31:0] TAG_MSG  = {"MSG", 8'h00};

   localparam logic [4:0] RTC_COL  = 5'd1;
   localparam logic [2:0] RTC_ROW  = 3'd1;
   localparam logic [4:0] RSSI_COL = 5'd17;
   localparam logic [2:0] RSSI_ROW = 3'd1;
   localparam logic [4:0] MSG_COL  = 5'd1;
   localparam logic [2:0] MSG_ROW  = 3'd4;

   typedef struct packed {
      logic [1:0] kind;
      logic       activity;
      logic [4:0] column;
      logic [2:0] row;
      logic [7:0] char_code;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic         load;
      rsp_item_type item;
   } rsp_load_type;

   function automatic rsp_item_type status_item(input logic act);
      rsp_item_type r;
      r.kind      = KIND_STATUS;
      r.activity  = act;
      r.column    = '0;
      r.row       = '0;
      r.char_code = '0;
      r.last      = 1'b1;
      return r;
   endfunction

   function automatic logic [7:0] tag_char(input logic [31:0] tag, input logic [1:0] pos);
      logic [7:0] c;
      case (pos)
         2'd0: c = tag[31:24];
         2'd1: c = tag[23:16];
         2'd2: c = tag[15:8];
         default: c = tag[7:0];
      endcase
      return c;
   endfunction

endpackage

### design/tlr_line_mem.sv
// ----------------------------------------------------------------------------
// tlr_line_mem
// Line store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tlr_line_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/tlr_rsp_reg.sv
// ----------------------------------------------------------------------------
// tlr_rsp_reg
// Output register of the result channel; holds one word until taken.
// ----------------------------------------------------------------------------
module tlr_rsp_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  tlr_pkg::rsp_load_type rsp_load,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic                  rsp_free,
   output tlr_pkg::rsp_item_type rsp_item
);

   logic                  valid_ff;
   tlr_pkg::rsp_item_type item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (rsp_load.load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load.load) begin
         item_ff <= rsp_load.item;
      end
   end

   assign rsp_free  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

### design/tagged_line_router.sv
// A non-newline byte's status word is in the output register in the cycle after acceptance.
// Newline: the scan steps through stored bytes up to the first space or zero (tag check and space search),
// then each payload byte takes a memory read state and a check state; output back-pressure can stall it.
// Input is held off until the line has been routed and its last word handed to the output register.
// Reset clears the fill count, the state machine and the output valid; the store reads as zero.
// ----------------------------------------------------------------------------
// tagged_line_router
// Collects bytes into a line store and routes tagged lines to a display.
// ----------------------------------------------------------------------------
module tagged_line_router #(
   parameter int LINE_CAPACITY = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_result_kind,
   output logic       rsp_activity,
   output logic [4:0] rsp_cursor_column,
   output logic [2:0] rsp_cursor_row,
   output logic [7:0] rsp_display_char,
   output logic       rsp_last
);

   localparam int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
   localparam int CW = $clog2(LINE_CAPACITY + 1);
   localparam logic [CW-1:0] CAP_C  = CW'(LINE_CAPACITY);
   localparam logic [CW-1:0] LAST_C = CW'(LINE_CAPACITY - 1);
   localparam logic [CW-1:0] TAG3_C = CW'(3);
   localparam logic [CW-1:0] TAG4_C = CW'(4);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_STATUS,
      ST_EMIT_RD,
      ST_EMIT_CHK,
      ST_FIN
   } state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         fill_ff, fill_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic                  rtc_ff, rtc_in;
   logic                  rssi_ff, rssi_in;
   logic                  msg_ff, msg_in;
   tlr_pkg::rsp_item_type pend_ff, pend_in;

   logic                  accept;
   logic                  wr_en;
   logic [AW-1:0]         rd_addr;
   logic [7:0]            rd_data;
   logic [7:0]            eff_byte;
   logic [CW-1:0]         idx_plus;
   logic                  rtc_now, rssi_now, msg_now, hit;
   logic [4:0]            hit_col;
   logic [2:0]            hit_row;
   logic                  rsp_free;
   tlr_pkg::rsp_load_type rsp_load;
   tlr_pkg::rsp_item_type rsp_item;

   assign accept   = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && rsp_free;
   assign wr_en    = accept && (req_rx_byte != tlr_pkg::NEWLINE_BYTE) && (fill_ff < CAP_C);
   assign idx_plus = idx_ff + CW'(1);
   // entries at or past the fill count read as cleared
   assign eff_byte = (idx_ff < fill_ff) ? rd_data : tlr_pkg::ZERO_BYTE;

   always_comb begin
      case (state_ff)
         ST_IDLE:     rd_addr = '0;
         ST_SCAN:     rd_addr = idx_plus[AW-1:0];
         default:     rd_addr = idx_ff[AW-1:0];
      endcase
   end

   tlr_line_mem #(
      .DEPTH (LINE_CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data (req_rx_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // tag flags including the byte under inspection
   always_comb begin
      rtc_now  = rtc_ff && ((idx_ff >= TAG3_C) ||
                 (eff_byte == tlr_pkg::tag_char(tlr_pkg::TAG_RTC, idx_ff[1:0])));
      rssi_now = rssi_ff && ((idx_ff >= TAG4_C) ||
                 (eff_byte == tlr_pkg::tag_char(tlr_pkg::TAG_RSSI, idx_ff[1:0])));
      msg_now  = msg_ff && ((idx_ff >= TAG3_C) ||
                 (eff_byte == tlr_pkg::tag_char(tlr_pkg::TAG_MSG, idx_ff[1:0])));
      hit      = rtc_now || rssi_now || msg_now;
      if (rtc_now) begin
         hit_col = tlr_pkg::RTC_COL;
         hit_row = tlr_pkg::RTC_ROW;
      end else if (rssi_now) begin
         hit_col = tlr_pkg::RSSI_COL;
         hit_row = tlr_pkg::RSSI_ROW;
      end else begin
         hit_col = tlr_pkg::MSG_COL;
         hit_row = tlr_pkg::MSG_ROW;
      end
   end

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      rtc_in        = rtc_ff;
      rssi_in       = rssi_ff;
      msg_in        = msg_ff;
      pend_in       = pend_ff;
      rsp_load.load = 1'b0;
      rsp_load.item = pend_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_rx_byte == tlr_pkg::NEWLINE_BYTE) begin
                  state_in = ST_SCAN;
                  idx_in   = '0;
                  rtc_in   = 1'b1;
                  rssi_in  = 1'b1;
                  msg_in   = 1'b1;
               end else begin
                  rsp_load.load = 1'b1;
                  rsp_load.item = tlr_pkg::status_item(1'b1);
                  if (wr_en) begin
                     fill_in = fill_ff + CW'(1);
                  end
               end
            end
         end
         ST_SCAN: begin
            rtc_in  = rtc_now;
            rssi_in = rssi_now;
            msg_in  = msg_now;
            if (eff_byte == tlr_pkg::ZERO_BYTE) begin
               state_in = ST_STATUS;
            end else if (eff_byte == tlr_pkg::SPACE_BYTE) begin
               if (hit) begin
                  pend_in.kind      = tlr_pkg::KIND_CURSOR;
                  pend_in.activity  = 1'b0;
                  pend_in.column    = hit_col;
                  pend_in.row       = hit_row;
                  pend_in.char_code = '0;
                  pend_in.last      = 1'b0;
                  idx_in            = idx_plus;
                  state_in          = ST_EMIT_RD;
               end else begin
                  state_in = ST_STATUS;
               end
            end else if (idx_ff == LAST_C) begin
               state_in = ST_STATUS;
            end else begin
               idx_in = idx_plus;
            end
         end
         ST_STATUS: begin
            if (rsp_free) begin
               rsp_load.load = 1'b1;
               rsp_load.item = tlr_pkg::status_item(1'b0);
               fill_in       = '0;
               state_in      = ST_IDLE;
            end
         end
         ST_EMIT_RD: begin
            if (idx_ff == CAP_C) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_EMIT_CHK;
            end
         end
         ST_EMIT_CHK: begin
            if (eff_byte == tlr_pkg::ZERO_BYTE) begin
               state_in = ST_FIN;
            end else if (rsp_free) begin
               // send the held word, hold this byte until its successor is known
               rsp_load.load     = 1'b1;
               pend_in.kind      = tlr_pkg::KIND_CHAR;
               pend_in.activity  = 1'b0;
               pend_in.column    = '0;
               pend_in.row       = '0;
               pend_in.char_code = eff_byte;
               pend_in.last      = 1'b0;
               idx_in            = idx_plus;
               state_in          = ST_EMIT_RD;
            end
         end
         ST_FIN: begin
            if (rsp_free) begin
               rsp_load.load      = 1'b1;
               rsp_load.item.last = 1'b1;
               fill_in            = '0;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      rtc_ff  <= rtc_in;
      rssi_ff <= rssi_in;
      msg_ff  <= msg_in;
      pend_ff <= pend_in;
   end

   tlr_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .rsp_load  (rsp_load),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_free  (rsp_free),
      .rsp_item  (rsp_item)
   );

   assign rsp_result_kind   = rsp_item.kind;
   assign rsp_activity      = rsp_item.activity;
   assign rsp_cursor_column = rsp_item.column;
   assign rsp_cursor_row    = rsp_item.row;
   assign rsp_display_char  = rsp_item.char_code;
   assign rsp_last          = rsp_item.last;

`include "tagged_line_router_assert.svh"

   `TLR_ASSERT_NOW(a_fill_bound, 1'b1, fill_ff <= CAP_C, "fill count beyond capacity")
   `TLR_ASSERT_NOW(a_ready_slot, req_ready, !rsp_valid || rsp_ready, "input taken without slot")
   `TLR_ASSERT_NEXT(a_newline_busy, accept && req_rx_byte == tlr_pkg::NEWLINE_BYTE, !req_ready, "newline not processed")
   `TLR_ASSERT_NEXT(a_byte_status, accept && req_rx_byte != tlr_pkg::NEWLINE_BYTE, rsp_valid && rsp_activity && rsp_last, "missing status word")

endmodule
